### rtl/core/slt_pkg.sv
`default_nettype none

package slt_pkg;

    // Table geometry.
    localparam int DEPTH       = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int KIND_W      = 2;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int STATUS_W    = 2;

    // Operation codes carried on the input word. The unused code behaves as a query.
    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_QUERY  = 2'd2
    } kind_t;

    // Completion codes carried on the result word.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE = 2'd0,
        STATUS_FULL = 2'd1,
        STATUS_MISS = 2'd2
    } status_t;

    // Shift commands broadcast from the top level to every cell.
    typedef struct packed {
        logic ins;
        logic rem;
    } ctrl_t;

endpackage

`default_nettype wire

### rtl/core/slt_cell.sv
`default_nettype none

module slt_cell (
    input  wire logic                           aclk,
    input  wire slt_pkg::ctrl_t                 ctrl,
    input  wire logic [slt_pkg::VALUE_WIDTH-1:0] key,
    input  wire logic                           occupied,
    input  wire logic                           lt_left,
    input  wire logic [slt_pkg::VALUE_WIDTH-1:0] left_entry,
    input  wire logic [slt_pkg::VALUE_WIDTH-1:0] right_entry,
    output logic      [slt_pkg::VALUE_WIDTH-1:0] entry,
    output logic                                lt,
    output logic                                hit,
    output logic                                at_pos
);
    import slt_pkg::*;

    logic [VALUE_WIDTH-1:0] entry_reg;
    logic [VALUE_WIDTH-1:0] entry_next;

    assign entry  = entry_reg;
    // Occupied cells below the search point form an unbroken run from cell zero.
    assign lt     = occupied && (entry_reg < key);
    assign at_pos = lt_left && !lt;
    assign hit    = occupied && lt_left && (entry_reg == key);

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.ins) begin
            if (at_pos) begin
                entry_next = key;
            end else if (!lt_left) begin
                entry_next = left_entry;
            end
        end
        if (ctrl.rem && !lt) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

### rtl/core/sorted_list_table_unit.sv
`default_nettype none

// Sorted table of up to sixteen unsigned 32-bit values, kept in ascending order.
//
// Each input word carries an operation (insert, remove or position query) and a
// value. Every input word produces exactly one result word holding the position
// of the first entry not less than the value, a found flag, a status code and the
// number of entries held after the operation.
//
// The table is a row of identical cells, one per entry. Every cell compares its
// entry with the value in parallel; an insert shifts the cells at and above the
// position up by one, a remove shifts them down by one, all in the same cycle.
// The result word is registered, so m_valid rises in the cycle after acceptance,
// and one word is taken per cycle as long as the receiver keeps up.
// When the receiver stalls, the held result blocks s_ready until it is taken;
// s_ready follows m_ready in the same cycle so no bubble is lost.
//
// Reset (synchronous, active low on aresetn) empties the table and drops any
// pending result. Entry storage itself is not cleared; the count alone decides
// which cells hold data. There is no start-up delay after reset.
module sorted_list_table_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [slt_pkg::KIND_W-1:0]        s_kind,
    input  wire logic [slt_pkg::VALUE_WIDTH-1:0]   s_value,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic      [slt_pkg::CNT_W-1:0]         m_position,
    output logic                                   m_found,
    output logic      [slt_pkg::STATUS_W-1:0]      m_status,
    output logic      [slt_pkg::CNT_W-1:0]         m_count
);
    import slt_pkg::*;

    logic                   accept;
    logic                   full;
    logic                   found;
    logic [CNT_W-1:0]       position;
    status_t                status;
    ctrl_t                  ctrl;

    logic [VALUE_WIDTH-1:0] cell_entry [DEPTH];
    logic [DEPTH-1:0]       cell_lt;
    logic [DEPTH-1:0]       cell_hit;
    logic [DEPTH-1:0]       cell_at_pos;
    logic [DEPTH-1:0]       cell_occupied;

    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   m_valid_reg;
    logic                   m_valid_next;
    logic [CNT_W-1:0]       m_position_reg;
    logic                   m_found_reg;
    logic [STATUS_W-1:0]    m_status_reg;
    logic [CNT_W-1:0]       m_count_reg;

    // A new word is taken whenever the output register is empty or being drained.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign full    = (count_reg == CNT_W'(DEPTH));

    // The row of cells. Cell zero sees an always-true left neighbor so that the
    // search point can land on it; the last cell refills from itself on remove.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                   lt_left;
        logic [VALUE_WIDTH-1:0] left_entry;
        logic [VALUE_WIDTH-1:0] right_entry;

        assign cell_occupied[g] = (CNT_W'(g) < count_reg);

        if (g == 0) begin : g_first
            assign lt_left    = 1'b1;
            assign left_entry = s_value;
        end else begin : g_inner_left
            assign lt_left    = cell_lt[g-1];
            assign left_entry = cell_entry[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_entry = cell_entry[g];
        end else begin : g_inner_right
            assign right_entry = cell_entry[g+1];
        end

        slt_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .key         (s_value),
            .occupied    (cell_occupied[g]),
            .lt_left     (lt_left),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (cell_entry[g]),
            .lt          (cell_lt[g]),
            .hit         (cell_hit[g]),
            .at_pos      (cell_at_pos[g])
        );
    end

    // Exactly one cell marks the search point, unless every cell is below the
    // value, in which case the position is the full depth.
    always_comb begin
        position = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (cell_at_pos[i]) begin
                position = position | CNT_W'(i);
            end
        end
        if (cell_lt[DEPTH-1]) begin
            position = CNT_W'(DEPTH);
        end
    end

    assign found = |cell_hit;

    always_comb begin
        ctrl       = '0;
        status     = STATUS_DONE;
        count_next = count_reg;
        case (kind_t'(s_kind))
            KIND_INSERT: begin
                if (full) begin
                    status = STATUS_FULL;
                end else begin
                    ctrl.ins   = accept;
                    count_next = accept ? count_reg + CNT_W'(1) : count_reg;
                end
            end
            KIND_REMOVE: begin
                if (found) begin
                    ctrl.rem   = accept;
                    count_next = accept ? count_reg - CNT_W'(1) : count_reg;
                end else begin
                    status = STATUS_MISS;
                end
            end
            KIND_QUERY: begin
                status = STATUS_DONE;
            end
            default: begin
                status = STATUS_DONE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_position_reg <= position;
            m_found_reg    <= found;
            m_status_reg   <= status;
            m_count_reg    <= count_next;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_position = m_position_reg;
    assign m_found    = m_found_reg;
    assign m_status   = m_status_reg;
    assign m_count    = m_count_reg;

endmodule

`default_nettype wire
